FILE: design/tmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmc_pkg
// Types, codes, reset values and helper functions of the thermostat mode
// controller.
// ----------------------------------------------------------------------------
package tmc_pkg;

    localparam int TMC_SAMPLES = 8;

    localparam int TEMP_W   = 8;
    localparam int TIMER_W  = 20;
    localparam int SUM_W    = 14;
    localparam int CNT_W    = 7;
    localparam int KIND_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = TIMER_W;
    localparam int DEC_BASE = 10;
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;

    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ONOFF  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UP     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DOWN   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_SP  = 3'd6;

    localparam logic [TEMP_W-1:0]  RST_MIN_SP     = 8'd35;
    localparam logic [TEMP_W-1:0]  RST_MAX_SP     = 8'd75;
    localparam logic [TEMP_W-1:0]  RST_STEP       = 8'd5;
    localparam logic [TEMP_W-1:0]  RST_DEADBAND   = 8'd5;
    localparam logic [TIMER_W-1:0] RST_TIMEOUT    = 20'd5000;
    localparam logic [TEMP_W-1:0]  RST_DEFAULT_SP = 8'd60;
    localparam logic [TEMP_W-1:0]  RST_STORED_SP  = 8'd60;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_ON  = 2'd1,
        MODE_SET = 2'd2
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TEMP_W-1:0] sample_temp;
    } t_in_item;

    typedef struct packed {
        logic              heater_on;
        logic              cooler_on;
        logic [1:0]        mode;
        logic              display_on;
        logic [4:0]        digit_tens;
        logic [3:0]        digit_ones;
        logic              led_color;
        logic              led_lit;
        logic              led_blink;
        logic              display_blink;
        logic [TEMP_W-1:0] setpoint_now;
        logic              save_setpoint;
    } t_out_item;

    // Stored setpoint if inside the limits, else the fallback.
    function automatic logic [TEMP_W-1:0] check_sp(
        input logic [TEMP_W-1:0] stored,
        input logic [TEMP_W-1:0] lo,
        input logic [TEMP_W-1:0] hi,
        input logic [TEMP_W-1:0] dflt
    );
        logic [TEMP_W-1:0] res;
        res = ((stored > hi) || (stored < lo)) ? dflt : stored;
        return res;
    endfunction

    // Divide by ten with a reciprocal multiply, exact over the 8-bit range:
    // {tens, ones}.
    function automatic logic [8:0] to_digits(input logic [TEMP_W-1:0] v);
        logic [15:0]       prod;
        logic [4:0]        q;
        logic [TEMP_W-1:0] tens_part;
        prod      = 16'(v) * 16'(DIV10_MUL);
        q         = prod[DIV10_SHIFT +: 5];
        tens_part = TEMP_W'(q * DEC_BASE);
        return {q, 4'(v - tens_part)};
    endfunction

endpackage
`default_nettype wire

FILE: design/tmc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmc_ctrl
// Controller state, configuration registers and the single-pass update that
// turns one event into the next state and its result.
// ----------------------------------------------------------------------------
module tmc_ctrl import tmc_pkg::*; #(
    parameter int SAMPLES = TMC_SAMPLES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire t_in_item              i_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out_item                  o_result
);

    localparam int RECIP_SHIFT = SUM_W + CNT_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SHIFT) / SAMPLES) + 1);
    localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(SAMPLES);

    logic [TEMP_W-1:0]  r_min, r_max, r_step, r_db, r_dflt, r_stored;
    logic [TIMER_W-1:0] r_timeout;
    t_mode              r_mode, n_mode;
    logic [TEMP_W-1:0]  r_sp, n_sp;
    logic [TEMP_W-1:0]  r_avg, n_avg;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic               active;
    logic               save;
    logic               heat, cool;
    logic [TEMP_W:0]    up_sum;
    logic [TEMP_W-1:0]  up_sp, dn_base, dn_sp, shown, cfg_v8;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   cnt_inc;
    logic [PROD_W-1:0]  avg_prod;
    logic [8:0]         digits;

    assign cfg_v8   = i_cfg_data[TEMP_W-1:0];
    assign active   = (r_mode != MODE_OFF);
    assign up_sum   = {1'b0, r_sp} + {1'b0, r_step};
    assign up_sp    = (up_sum > {1'b0, r_max}) ? r_max : up_sum[TEMP_W-1:0];
    assign dn_base  = (r_sp >= r_step) ? (r_sp - r_step) : '0;
    assign dn_sp    = (dn_base < r_min) ? r_min : dn_base;
    assign sum_add  = r_sum + SUM_W'(i_item.sample_temp);
    assign cnt_inc  = r_cnt + CNT_W'(1);
    assign avg_prod = PROD_W'(sum_add) * PROD_W'(RECIP);

    always_comb begin
        n_mode  = r_mode;
        n_sp    = r_sp;
        n_avg   = r_avg;
        n_timer = r_timer;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        save    = 1'b0;
        unique case (i_item.kind)
            KIND_TICK: begin
                if (active && (r_timer != '1)) n_timer = r_timer + TIMER_W'(1);
            end
            KIND_SAMPLE: begin
                if (active) begin
                    if (cnt_inc >= CNT_LAST) begin
                        n_avg = avg_prod[RECIP_SHIFT +: TEMP_W];
                        n_sum = '0;
                        n_cnt = '0;
                    end else begin
                        n_sum = sum_add;
                        n_cnt = cnt_inc;
                    end
                end
            end
            KIND_ONOFF: begin
                n_mode  = active ? MODE_OFF : MODE_ON;
                n_timer = '0;
            end
            KIND_UP, KIND_DOWN: begin
                if (active) begin
                    if (r_mode == MODE_SET) begin
                        n_sp = (i_item.kind == KIND_UP) ? up_sp : dn_sp;
                        save = 1'b1;
                    end
                    n_mode  = MODE_SET;
                    n_timer = '0;
                end
            end
            default: begin
            end
        endcase
        if ((n_mode == MODE_SET) && (n_timer > r_timeout)) begin
            n_mode  = MODE_ON;
            n_timer = '0;
        end

        heat = 1'b0;
        cool = 1'b0;
        if (n_mode != MODE_OFF) begin
            if (({1'b0, n_avg} + {1'b0, r_db}) < {1'b0, n_sp}) heat = 1'b1;
            else if ({1'b0, n_avg} > ({1'b0, n_sp} + {1'b0, r_db})) cool = 1'b1;
        end
        unique case (n_mode)
            MODE_SET: shown = n_sp;
            MODE_ON:  shown = n_avg;
            default:  shown = '0;
        endcase
        digits = to_digits(shown);

        o_result.heater_on     = heat;
        o_result.cooler_on     = cool;
        o_result.mode          = n_mode;
        o_result.display_on    = (n_mode != MODE_OFF);
        o_result.digit_tens    = digits[8:4];
        o_result.digit_ones    = digits[3:0];
        o_result.led_color     = (n_mode == MODE_SET);
        o_result.led_lit       = (n_mode != MODE_OFF);
        o_result.led_blink     = (n_mode == MODE_ON) && heat;
        o_result.display_blink = (n_mode == MODE_SET);
        o_result.setpoint_now  = n_sp;
        o_result.save_setpoint = save;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= RST_MIN_SP;
            r_max     <= RST_MAX_SP;
            r_step    <= RST_STEP;
            r_db      <= RST_DEADBAND;
            r_timeout <= RST_TIMEOUT;
            r_dflt    <= RST_DEFAULT_SP;
            r_stored  <= RST_STORED_SP;
            r_mode    <= MODE_OFF;
            r_sp      <= check_sp(RST_STORED_SP, RST_MIN_SP, RST_MAX_SP, RST_DEFAULT_SP);
            r_avg     <= RST_DEFAULT_SP;
            r_timer   <= '0;
            r_sum     <= '0;
            r_cnt     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_SP:   r_min     <= cfg_v8;
                CFG_MAX_SP:   r_max     <= cfg_v8;
                CFG_STEP:     r_step    <= cfg_v8;
                CFG_DEADBAND: r_db      <= cfg_v8;
                CFG_TIMEOUT:  r_timeout <= i_cfg_data;
                CFG_DEFAULT_SP: begin
                    r_dflt <= cfg_v8;
                    r_avg  <= cfg_v8;
                    r_sp   <= check_sp(r_stored, r_min, r_max, cfg_v8);
                end
                CFG_STORED_SP: begin
                    r_stored <= cfg_v8;
                    r_sp     <= check_sp(cfg_v8, r_min, r_max, r_dflt);
                end
                default: begin
                end
            endcase
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_sp    <= n_sp;
            r_avg   <= n_avg;
            r_timer <= n_timer;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: design/thermostat_mode_controller_core.sv
// Path: an item is held in the input register, then its result in the result
// register; the step waits while a held result is not yet taken.
// Throughput: one item per cycle unless stalled; one pass of update logic.
// Reset: synchronous, active low; clears both stages, sets off mode and the
// configuration defaults, and loads the range-checked stored setpoint.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thermostat_mode_controller_core
// Bang-bang thermostat with deadband, set-mode timeout and display outputs.
// ----------------------------------------------------------------------------
module thermostat_mode_controller_core import tmc_pkg::*; #(
    parameter int SAMPLES = TMC_SAMPLES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item result;
    logic      adv;

    assign adv         = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || adv;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    tmc_ctrl #(
        .SAMPLES (SAMPLES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv),
        .i_item     (r_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) r_in_vld <= i_in_valid;
            if (adv) r_out_vld <= 1'b1;
            else if (i_out_ready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in <= i_in_item;
        if (adv) r_out <= result;
    end

endmodule
`default_nettype wire

FILE: design/tmc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmc_checker
// Port-level checks of the thermostat controller, bound to the top level.
// ----------------------------------------------------------------------------
module tmc_checker import tmc_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire t_out_item             o_out_item
);

    a_no_heat_and_cool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.heater_on && o_out_item.cooler_on))
        else $error("heater and cooler both driven");

    a_off_is_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.mode == MODE_OFF)) |->
            (!o_out_item.display_on && !o_out_item.heater_on && !o_out_item.cooler_on
             && !o_out_item.led_lit))
        else $error("output active in off mode");

    a_save_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.save_setpoint) |-> (o_out_item.mode == MODE_SET))
        else $error("save strobe outside set mode");

    a_blink_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.led_blink) |->
            (o_out_item.heater_on && (o_out_item.mode == MODE_ON)))
        else $error("led blink without heating in on mode");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind thermostat_mode_controller_core tmc_checker u_tmc_checker (.*);
`default_nettype wire
